// ----- rtl/command_frame_receiver_top_defines.svh -----
// Assertion macros shared by the frame receiver checker.
`ifndef COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cfr_pkg.sv -----
// Constants and types shared by the frame receiver and its checker.
package cfr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 7;

  localparam logic [BYTE_W-1:0] CMD_MASK       = 8'h90;
  localparam logic [BYTE_W-1:0] TERMINATOR     = 8'h0A;
  localparam logic [BYTE_W-1:0] START_MARK_RST = 8'h0A;
  localparam logic [BYTE_W-1:0] END_MARK_RST   = 8'h0B;

  typedef enum logic [0:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } cfg_reg_t;

endpackage

// ----- rtl/command_frame_receiver_top.sv -----
// Top level of the marker-delimited command frame receiver.
//
// Usage: one received serial byte enters per word on the in_ channel
// (in_valid, in_ready, in_rx_byte). Every byte produces exactly one result
// word on the out_ channel: out_kept says whether the byte joined the frame
// under way, out_position gives its place in the frame, and on the line-feed
// terminator of a valid frame out_frame_done rises with out_command and
// out_frame_length. Fields that do not apply read as zero.
// The byte is captured in an input register when it is accepted, and the
// decision is then made and registered in the result register stage.
// The receiver takes one byte per cycle unless out_ready stalls it; the only
// loop is the phase and byte count update: a few compares and one increment.
// The cfg_ port writes the start marker (index 0) and end marker (index 1);
// the user must make writes only while the receiver is idle; the block has no guard.
// Reset (synchronous, active low) returns the receiver to the hunt with a
// zero byte count, restores the markers to 0x0A and 0x0B and empties both
// register stages. When the receiver stalls out_ready, the result holds and
// one further byte may wait in the input register before in_ready falls.
module command_frame_receiver_top
  import cfr_pkg::*;
#(
  parameter int MAX_LENGTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kept,
  output logic [POS_W-1:0]  out_position,
  output logic              out_frame_done,
  output logic [BYTE_W-1:0] out_command,
  output logic [LEN_W-1:0]  out_frame_length,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata
);

  // The count must be able to hold MAX_LENGTH itself for the limit compare.
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int EXT_W = CNT_W + LEN_W;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LENGTH);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CMD,
    PH_DATA,
    PH_END
  } phase_t;

  // Configuration registers.
  logic [BYTE_W-1:0] start_mark_r;
  logic [BYTE_W-1:0] end_mark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mark_r <= START_MARK_RST;
      end_mark_r   <= END_MARK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_MARKER: start_mark_r <= cfg_wdata;
        REG_END_MARKER:   end_mark_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_adv;
  logic              s1_fire;

  assign out_adv  = !out_valid || out_ready;
  assign s1_fire  = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Frame state and result registers.
  phase_t            phase_r,  phase_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [BYTE_W-1:0] cmd_r,    cmd_nxt;
  logic              out_valid_r;
  logic              kept_r,   kept_nxt;
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic              done_r,   done_nxt;
  logic [BYTE_W-1:0] ocmd_r,   ocmd_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;

  logic [CNT_W-1:0] count_inc;
  logic             at_limit;
  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] len_ext;

  assign count_inc = count_r + 1'b1;
  assign at_limit  = (count_inc >= LIMIT);
  assign pos_ext   = EXT_W'(count_r);
  assign len_ext   = EXT_W'(count_inc);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    kept_nxt  = 1'b0;
    done_nxt  = 1'b0;
    ocmd_nxt  = '0;
    len_nxt   = '0;
    case (phase_r)
      PH_HUNT: begin
        if (s1_byte_r == start_mark_r) begin
          kept_nxt  = 1'b1;
          count_nxt = count_inc;
          phase_nxt = PH_CMD;
        end else begin
          count_nxt = '0;
        end
      end
      PH_CMD: begin
        if ((s1_byte_r & CMD_MASK) == CMD_MASK) begin
          kept_nxt  = 1'b1;
          cmd_nxt   = s1_byte_r;
          count_nxt = count_inc;
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_HUNT;
          count_nxt = '0;
        end
      end
      PH_DATA: begin
        // The length limit wins even over an end marker.
        if (at_limit) begin
          phase_nxt = PH_HUNT;
          count_nxt = '0;
        end else begin
          kept_nxt  = 1'b1;
          count_nxt = count_inc;
          if (s1_byte_r == end_mark_r) begin
            phase_nxt = PH_END;
          end
        end
      end
      PH_END: begin
        // The terminator completes the frame even at the length limit.
        if (s1_byte_r == TERMINATOR) begin
          kept_nxt  = 1'b1;
          done_nxt  = 1'b1;
          ocmd_nxt  = cmd_r;
          len_nxt   = len_ext[LEN_W-1:0];
          phase_nxt = PH_HUNT;
          count_nxt = '0;
        end else if (at_limit) begin
          phase_nxt = PH_HUNT;
          count_nxt = '0;
        end else begin
          kept_nxt  = 1'b1;
          count_nxt = count_inc;
          if (s1_byte_r != end_mark_r) begin
            phase_nxt = PH_DATA;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        count_nxt = '0;
      end
    endcase
    pos_nxt = kept_nxt ? pos_ext[POS_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      count_r     <= '0;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        cmd_r   <= cmd_nxt;
        kept_r  <= kept_nxt;
        pos_r   <= pos_nxt;
        done_r  <= done_nxt;
        ocmd_r  <= ocmd_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kept         = kept_r;
  assign out_position     = pos_r;
  assign out_frame_done   = done_r;
  assign out_command      = ocmd_r;
  assign out_frame_length = len_r;

endmodule

// ----- rtl/cfr_checker.sv -----
// Port-level checker for the frame receiver, bound to the top level.
`include "command_frame_receiver_top_defines.svh"
module cfr_checker
  import cfr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_kept,
  input logic [POS_W-1:0]  out_position,
  input logic              out_frame_done,
  input logic [BYTE_W-1:0] out_command,
  input logic [LEN_W-1:0]  out_frame_length
);

  // A stalled result word stays valid and holds its kept, position and done flags.
  `CFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_kept) && $stable(out_position) && $stable(out_frame_done),
    "result word changed while stalled")

  // A completed frame reports its terminator as a kept byte.
  `CFR_ASSERT_NOW(a_done_kept, out_valid && out_frame_done, out_kept,
    "frame completion on a byte that was not kept")

  // A dropped byte carries no position and completes nothing.
  `CFR_ASSERT_NOW(a_drop_clean, out_valid && !out_kept,
    out_position == '0 && !out_frame_done,
    "dropped byte carries frame information")

  // Command and length are zero unless a frame completes.
  `CFR_ASSERT_NOW(a_idle_fields, out_valid && !out_frame_done,
    out_command == '0 && out_frame_length == '0,
    "command or length shown without frame completion")

  // The terminator sits at the last place of the frame.
  `CFR_ASSERT_NOW(a_term_pos, out_valid && out_frame_done,
    out_position == POS_W'(out_frame_length - 1'b1),
    "terminator position disagrees with frame length")

endmodule

bind command_frame_receiver_top cfr_checker u_cfr_checker (.*);

// ----- tb/tb_command_frame_receiver_top.sv -----
// Self-checking testbench for the marker-delimited command frame receiver.
module tb_command_frame_receiver_top;
  import cfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Frame length limit used both for the block and for the local prediction.
  localparam int FRAME_MAX = 64;
  // Generous ceiling on the whole run, far above the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;
  // Roughly how many frame bytes the random part sends.
  localparam int RANDOM_BYTES = 1300;

  // Receiver phases as the prediction tracks them.
  typedef enum logic [1:0] {
    RX_HUNT     = 2'd0,
    RX_COMMAND  = 2'd1,
    RX_DATA     = 2'd2,
    RX_END_SEEN = 2'd3
  } rx_phase_t;

  // One result word, field by field, at the widths of the block's ports.
  typedef struct packed {
    logic              kept;
    logic [POS_W-1:0]  position;
    logic              frame_done;
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  frame_length;
  } rx_word_t;

  // The frame checker predicts one result word per accepted byte and holds the
  // predictions in order until the block's result words arrive.
  class frame_checker;
    rx_phase_t         phase;
    int unsigned       byte_count;
    logic [BYTE_W-1:0] command_byte;
    logic [BYTE_W-1:0] start_mark;
    logic [BYTE_W-1:0] end_mark;
    rx_word_t          expected_words[$];
    int                errors;

    function new();
      phase        = RX_HUNT;
      byte_count   = 0;
      command_byte = '0;
      start_mark   = START_MARK_RST;
      end_mark     = END_MARK_RST;
      errors       = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_markers(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e);
      start_mark = s;
      end_mark   = e;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void restart_hunt();
      phase      = RX_HUNT;
      byte_count = 0;
    endfunction

    // Works out the result word that one accepted byte causes.
    function void note_byte(logic [BYTE_W-1:0] b);
      rx_word_t    w;
      int unsigned pos;
      int unsigned nxt;
      w   = '0;
      pos = byte_count;
      nxt = byte_count + 1;
      case (phase)
        RX_HUNT: begin
          if (b == start_mark) begin
            w.kept     = 1'b1;
            byte_count = nxt;
            phase      = RX_COMMAND;
          end else begin
            restart_hunt();
          end
        end
        RX_COMMAND: begin
          if ((b & CMD_MASK) == CMD_MASK) begin
            w.kept       = 1'b1;
            command_byte = b;
            byte_count   = nxt;
            phase        = RX_DATA;
          end else begin
            restart_hunt();
          end
        end
        RX_DATA: begin
          // The length limit wins even over an end marker.
          if (nxt >= FRAME_MAX) begin
            restart_hunt();
          end else begin
            w.kept     = 1'b1;
            byte_count = nxt;
            if (b == end_mark) phase = RX_END_SEEN;
          end
        end
        default: begin
          if (b == TERMINATOR) begin
            w.kept         = 1'b1;
            w.frame_done   = 1'b1;
            w.command      = command_byte;
            w.frame_length = LEN_W'(nxt);
            restart_hunt();
          end else if (nxt >= FRAME_MAX) begin
            restart_hunt();
          end else begin
            w.kept     = 1'b1;
            byte_count = nxt;
            if (b != end_mark) phase = RX_DATA;
          end
        end
      endcase
      if (w.kept) w.position = POS_W'(pos);
      expected_words.push_back(w);
    endfunction

    // Compares one result word from the block with the oldest prediction.
    task check_word(rx_word_t got);
      rx_word_t exp;
      if (expected_words.size() == 0) begin
        report("result word arrived with no byte outstanding");
      end else begin
        exp = expected_words.pop_front();
        if (got.kept !== exp.kept)
          report($sformatf("kept %0b, expected %0b", got.kept, exp.kept));
        if (got.position !== exp.position)
          report($sformatf("position %0d, expected %0d", got.position, exp.position));
        if (got.frame_done !== exp.frame_done)
          report($sformatf("frame_done %0b, expected %0b", got.frame_done, exp.frame_done));
        if (got.command !== exp.command)
          report($sformatf("command %02h, expected %02h", got.command, exp.command));
        if (got.frame_length !== exp.frame_length)
          report($sformatf("frame_length %0d, expected %0d",
                           got.frame_length, exp.frame_length));
      end
    endtask

    task check_leftover();
      if (expected_words.size() != 0) begin
        report($sformatf("%0d result words never arrived", expected_words.size()));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic              out_kept;
  logic [POS_W-1:0]  out_position;
  logic              out_frame_done;
  logic [BYTE_W-1:0] out_command;
  logic [LEN_W-1:0]  out_frame_length;
  logic              cfg_wr_en;
  logic [0:0]        cfg_index;
  logic [BYTE_W-1:0] cfg_wdata;

  frame_checker frames;

  // Percentages of cycles in which the sender and the receiver hold off.
  int send_idle;
  int recv_idle;
  // Frame bytes sent so far; noise bytes in the hunt are not counted.
  int frame_bytes;
  int cycles;

  command_frame_receiver_top #(
    .MAX_LENGTH(FRAME_MAX)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kept        (out_kept),
    .out_position    (out_position),
    .out_frame_done  (out_frame_done),
    .out_command     (out_command),
    .out_frame_length(out_frame_length),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every input starts at a known value before the first edge.
  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    out_ready  <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= REG_START_MARKER;
    cfg_wdata  <= '0;
  end

  // The receiver side raises and drops ready at random, at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Result words are taken at the edge where valid and ready were both high.
  // Reading in the active region sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      frames.check_word('{kept: out_kept, position: out_position,
                          frame_done: out_frame_done, command: out_command,
                          frame_length: out_frame_length});
    end
  end

  // Hard stop should the block hang.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one byte and returns at the edge where it was accepted. Valid is
  // only lowered when the sender decides to idle before this byte, so it is
  // never dropped and raised again in the same time step.
  task automatic send_byte(logic [BYTE_W-1:0] b, bit counted);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames.note_byte(b);
    if (counted) frame_bytes++;
  endtask

  // The sender stops and waits until every outstanding result word has come,
  // then idles longer to cover the two register stages.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (frames.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Writes the start marker and then the end marker while the block is idle.
  task automatic set_markers(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= REG_END_MARKER;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frames.set_markers(s, e);
  endtask

  // One random frame: mostly well formed with random content, sometimes with
  // a bad command, a missing end marker or a wrong terminator. Most frames are
  // short; a few run up against the length limit.
  task automatic send_frame();
    int                n;
    int                r;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] d;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
    send_byte(frames.start_mark, 1'b1);
    if ($urandom_range(99) < 90) cmd = 8'($urandom_range(255)) | CMD_MASK;
    else cmd = 8'($urandom_range(255));
    send_byte(cmd, 1'b1);
    r = $urandom_range(99);
    if (r < 80) n = $urandom_range(0, 8);
    else if (r < 90) n = $urandom_range(9, 40);
    else n = $urandom_range(57, 62);
    repeat (n) begin
      // An early end marker followed by a plain byte sends it back to data.
      if ($urandom_range(99) < 8) d = frames.end_mark;
      else d = 8'($urandom_range(255));
      send_byte(d, 1'b1);
    end
    if ($urandom_range(99) < 90) begin
      send_byte(frames.end_mark, 1'b1);
      if ($urandom_range(99) < 15) send_byte(frames.end_mark, 1'b1);
    end
    if ($urandom_range(99) < 90) send_byte(TERMINATOR, 1'b1);
    else send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    logic [BYTE_W-1:0] seg_start [6];
    logic [BYTE_W-1:0] seg_end   [6];
    int                target;

    frames      = new();
    send_idle   = 15;
    recv_idle   = 61;
    frame_bytes = 0;
    cycles      = 0;

    // Marker settings per random segment: both extremes each way round, an
    // end marker equal to the terminator, equal markers that also pass the
    // command check, and two random settings.
    seg_start[0] = 8'h00; seg_end[0] = 8'hFF;
    seg_start[1] = 8'hFF; seg_end[1] = 8'h00;
    seg_start[2] = 8'($urandom_range(255)); seg_end[2] = 8'($urandom_range(255));
    seg_start[3] = 8'h0A; seg_end[3] = TERMINATOR;
    seg_start[4] = 8'h9F; seg_end[4] = 8'h9F;
    seg_start[5] = 8'($urandom_range(255)); seg_end[5] = 8'($urandom_range(255));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset markers. A full frame with the command byte
    // exactly at the mask, extreme data and a repeated end marker.
    send_byte(8'h0A, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(TERMINATOR, 1'b0);
    // Wrong start bytes are dropped in the hunt.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Wrong command bytes, the start marker itself among them, and commands
    // with only one of the two mask bits set.
    send_byte(8'h0A, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h10, 1'b0);
    // End marker followed by a plain byte goes back to the data phase.
    send_byte(8'h0A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(TERMINATOR, 1'b0);
    drain();

    // Random part in six segments. The first pair has a slow receiver, the
    // second a slow sender, and the last pair runs with no idling at all.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle = 15;
        recv_idle = 61;
      end else if (seg < 4) begin
        send_idle = 61;
        recv_idle = 15;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_markers(seg_start[seg], seg_end[seg]);
      target = (RANDOM_BYTES * (seg + 1)) / 6;
      while (frame_bytes < target) send_frame();
      drain();
    end

    frames.check_leftover();
    if (frames.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
